// File: design/cct_pkg.sv
// types and constants for the cook timer controller
package cct_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_DIGIT  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_POLL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_HEAT  = 3'b010,
    MODE_FAULT = 3'b100
  } mode_t;

  localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_CODE_HEAT  = 2'd1;
  localparam logic [1:0] MODE_CODE_FAULT = 2'd2;

  localparam logic [7:0] TPS_RESET   = 8'd122;
  localparam logic [6:0] SEC_MAX     = 7'd59;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [2:0] DIGITS_FULL = 3'd4;

  localparam logic [2:0] CFG_REG_TPS = 3'd0;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] code;
    code = MODE_CODE_IDLE;
    unique case (m)
      MODE_IDLE:  code = MODE_CODE_IDLE;
      MODE_HEAT:  code = MODE_CODE_HEAT;
      MODE_FAULT: code = MODE_CODE_FAULT;
      default:    code = MODE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: design/cook_timer_controller.sv
// cook timer controller: digit entry, sensor polls and heating countdown
//
// channel  direction  handshake                       payload
// in_      slave      in_tvalid / in_tready           in_tdata, in_tuser
// out_     master     out_tvalid / out_tready         out_tdata
// cfg_     apb slave  psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// one item per cycle sustained while the output is not stalled; an item that is taken
// passes the input register, then the state update into the result register
// rst_n is synchronous, active low; it sets idle mode, zero time, 122 ticks
// a stalled output holds its item; the input register still takes one more
// item, then in_tready drops until the output is taken
module cook_timer_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // key_digit[3:0], door_closed[4], food_present[5],
                                  // start_pressed[6], zero[7]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // mode[1:0], heater_on[2], minutes[9:3],
                                  // seconds[16:10], digits_entered[19:17], zero[23:20]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              s1_valid_r;
  cct_pkg::cmd_t     s1_cmd_r;
  logic [3:0]        s1_digit_r;
  logic              s1_door_r;
  logic              s1_food_r;
  logic              s1_start_r;

  logic              out_valid_r;
  logic [23:0]       out_data_r;

  cct_pkg::mode_t    mode_r, mode_nxt;
  logic [6:0]        min_r, min_nxt;
  logic [6:0]        sec_r, sec_nxt;
  logic [7:0]        tick_r, tick_nxt;
  logic              cancel_r, cancel_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [7:0]        tps_r;

  logic              adv;
  logic              cfg_wr;
  logic              time_zero;
  logic              go;
  logic [7:0]        tick_inc;
  logic [6:0]        digit_ext;
  logic [6:0]        min_x10;
  logic [6:0]        sec_x10;
  logic [23:0]       res_data;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // apb register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == cct_pkg::CFG_REG_TPS[0]);
  assign cfg_prdata = (cfg_paddr[2] == cct_pkg::CFG_REG_TPS[0]) ? {24'd0, tps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= cct_pkg::TPS_RESET;
    end else if (cfg_wr) begin
      tps_r <= cfg_pwdata[7:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r   <= cct_pkg::cmd_t'(in_tuser);
      s1_digit_r <= in_tdata[3:0];
      s1_door_r  <= in_tdata[4];
      s1_food_r  <= in_tdata[5];
      s1_start_r <= in_tdata[6];
    end
  end

  // state update
  assign time_zero = (min_r == 7'd0) && (sec_r == 7'd0);
  assign go        = s1_start_r && s1_door_r && s1_food_r;
  assign tick_inc  = tick_r + 8'd1;
  assign digit_ext = {3'd0, s1_digit_r};
  // entry digits stay below ten, so the old value is its own last digit
  assign min_x10   = {min_r[3:0], 3'b000} + {min_r[5:0], 1'b0};
  assign sec_x10   = {sec_r[3:0], 3'b000} + {sec_r[5:0], 1'b0};

  always_comb begin
    mode_nxt   = mode_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    tick_nxt   = tick_r;
    cancel_nxt = cancel_r;
    idx_nxt    = idx_r;
    unique case (s1_cmd_r)
      cct_pkg::CMD_TICK: begin
        if (mode_r == cct_pkg::MODE_HEAT) begin
          if ((tick_inc >= tps_r) || (tick_inc == 8'd0)) begin
            tick_nxt = 8'd0;
            if (!time_zero) begin
              if (sec_r == 7'd0) begin
                min_nxt = min_r - 7'd1;
                sec_nxt = cct_pkg::SEC_MAX;
              end else begin
                sec_nxt = sec_r - 7'd1;
              end
            end
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      cct_pkg::CMD_DIGIT: begin
        if ((mode_r == cct_pkg::MODE_IDLE) && (s1_digit_r <= cct_pkg::DIGIT_MAX)
            && (idx_r < cct_pkg::DIGITS_FULL)) begin
          case (idx_r[1:0])
            2'd0:    min_nxt = digit_ext;
            2'd1:    min_nxt = min_x10 + digit_ext;
            2'd2:    sec_nxt = digit_ext;
            default: sec_nxt = sec_x10 + digit_ext;
          endcase
          idx_nxt = idx_r + 3'd1;
        end
      end
      cct_pkg::CMD_CANCEL: begin
        cancel_nxt = 1'b1;
      end
      cct_pkg::CMD_POLL: begin
        if (cancel_r || time_zero) begin
          cancel_nxt = 1'b0;
          min_nxt    = 7'd0;
          sec_nxt    = 7'd0;
          idx_nxt    = 3'd0;
          mode_nxt   = cct_pkg::MODE_IDLE;
        end else begin
          unique case (mode_r)
            cct_pkg::MODE_HEAT: begin
              if (!s1_door_r || !s1_food_r) begin
                mode_nxt = cct_pkg::MODE_FAULT;
                idx_nxt  = 3'd0;
              end
            end
            cct_pkg::MODE_FAULT: begin
              if (go) begin
                mode_nxt = cct_pkg::MODE_HEAT;
                idx_nxt  = 3'd0;
              end
            end
            default: begin
              mode_nxt = go ? cct_pkg::MODE_HEAT : cct_pkg::MODE_FAULT;
              idx_nxt  = 3'd0;
            end
          endcase
        end
      end
      default: begin
        cancel_nxt = cancel_r;
      end
    endcase
  end

  assign res_data = {4'd0, idx_nxt, sec_nxt, min_nxt,
                     (mode_nxt == cct_pkg::MODE_HEAT),
                     cct_pkg::mode_code(mode_nxt)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cct_pkg::MODE_IDLE;
      min_r    <= 7'd0;
      sec_r    <= 7'd0;
      tick_r   <= 8'd0;
      cancel_r <= 1'b0;
      idx_r    <= 3'd0;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      min_r    <= min_nxt;
      sec_r    <= sec_nxt;
      tick_r   <= tick_nxt;
      cancel_r <= cancel_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_data;
    end
  end

  // checks
  a_digits_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 3'd0) |-> (mode_r == cct_pkg::MODE_IDLE))
    else $error("digit count set outside idle");

  a_digits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cct_pkg::DIGITS_FULL)
    else $error("digit count above four");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && s1_valid_r))
    else $error("input held off without an output stall");

  a_heater_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[1:0] == cct_pkg::MODE_CODE_HEAT)))
    else $error("heater flag does not match mode");

endmodule

// File: bench/tb_top.sv
// testbench for the cook timer controller: random and directed items against a state predictor
module tb_top;

  typedef struct packed {
    cct_pkg::cmd_t cmd;
    logic [3:0]    key;
    logic          start;
    logic          food;
    logic          door;
  } oven_event_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       heater;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [2:0] digits;
  } display_t;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // key_digit[3:0], door_closed[4], food_present[5], start_pressed[6]
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // mode[1:0], heater_on[2], minutes[9:3], seconds[16:10], digits[19:17]
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cook_timer_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predicted oven state
  logic [1:0] oven_mode = cct_pkg::MODE_CODE_IDLE;
  logic [6:0] oven_min = '0;
  logic [6:0] oven_sec = '0;
  logic [7:0] oven_ticks = '0;
  logic       oven_cancel = 1'b0;
  logic [2:0] oven_digits = '0;
  logic [7:0] oven_tps = cct_pkg::TPS_RESET;

  oven_event_t pending_events[$];
  display_t    expected_display[$];
  oven_event_t driven_event;
  int          events_queued = 0;
  int          events_accepted = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;
  logic        calm;

  assign calm = events_accepted >= 700 && events_accepted < 1000;

  function automatic display_t apply_event(oven_event_t ev);
    logic [7:0] next_count;
    logic       time_zero;
    logic       go;
    display_t   d;
    time_zero = oven_min == 7'd0 && oven_sec == 7'd0;
    go = ev.start && ev.door && ev.food;
    case (ev.cmd)
      cct_pkg::CMD_TICK: begin
        if (oven_mode == cct_pkg::MODE_CODE_HEAT) begin
          next_count = oven_ticks + 8'd1;
          if (next_count >= oven_tps || next_count == 8'd0) begin
            oven_ticks = '0;
            if (!time_zero) begin
              if (oven_sec == 7'd0) begin
                oven_min = oven_min - 7'd1;
                oven_sec = cct_pkg::SEC_MAX;
              end else begin
                oven_sec = oven_sec - 7'd1;
              end
            end
          end else begin
            oven_ticks = next_count;
          end
        end
      end
      cct_pkg::CMD_DIGIT: begin
        if (oven_mode == cct_pkg::MODE_CODE_IDLE && ev.key <= cct_pkg::DIGIT_MAX
            && oven_digits < cct_pkg::DIGITS_FULL) begin
          case (oven_digits)
            3'd0: oven_min = 7'(ev.key);
            3'd1: oven_min = 7'((oven_min % 10) * 10 + ev.key);
            3'd2: oven_sec = 7'(ev.key);
            default: oven_sec = 7'((oven_sec % 10) * 10 + ev.key);
          endcase
          oven_digits = oven_digits + 3'd1;
        end
      end
      cct_pkg::CMD_CANCEL: oven_cancel = 1'b1;
      cct_pkg::CMD_POLL: begin
        if (oven_cancel || time_zero) begin
          oven_cancel = 1'b0;
          oven_min = '0;
          oven_sec = '0;
          oven_digits = '0;
          oven_mode = cct_pkg::MODE_CODE_IDLE;
        end else if (oven_mode == cct_pkg::MODE_CODE_HEAT) begin
          if (!ev.door || !ev.food) begin
            oven_mode = cct_pkg::MODE_CODE_FAULT;
            oven_digits = '0;
          end
        end else if (oven_mode == cct_pkg::MODE_CODE_FAULT) begin
          if (go) begin
            oven_mode = cct_pkg::MODE_CODE_HEAT;
            oven_digits = '0;
          end
        end else begin
          oven_mode = go ? cct_pkg::MODE_CODE_HEAT : cct_pkg::MODE_CODE_FAULT;
          oven_digits = '0;
        end
      end
    endcase
    d.mode = oven_mode;
    d.heater = oven_mode == cct_pkg::MODE_CODE_HEAT;
    d.minutes = oven_min;
    d.seconds = oven_sec;
    d.digits = oven_digits;
    return d;
  endfunction

  function automatic void check_field(string label, int want, int got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d actual %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_display.push_back(apply_event(driven_event));
        events_accepted <= events_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
          driven_event = pending_events.pop_front();
          in_tdata <= {1'b0, driven_event.start, driven_event.food, driven_event.door,
                       driven_event.key};
          in_tuser <= driven_event.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    display_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_display.size() == 0) begin
          $display("%0t unexpected item: expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_display.pop_front();
          check_field("mode", int'(want.mode), int'(out_tdata[1:0]));
          check_field("heater_on", int'(want.heater), int'(out_tdata[2]));
          check_field("minutes", int'(want.minutes), int'(out_tdata[9:3]));
          check_field("seconds", int'(want.seconds), int'(out_tdata[16:10]));
          check_field("digits_entered", int'(want.digits), int'(out_tdata[19:17]));
        end
        results_seen <= results_seen + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready && (results_seen == 300 || results_seen == 1300)) begin
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || $urandom_range(99) >= 30;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_event(cct_pkg::cmd_t c, logic [3:0] key, logic [2:0] sensors);
    oven_event_t ev;
    ev.cmd = c;
    ev.key = key;
    ev.start = sensors[2];
    ev.food = sensors[1];
    ev.door = sensors[0];
    pending_events.push_back(ev);
    events_queued++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || in_tvalid || expected_display.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tps(logic [7:0] value);
    wait_drained();
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(4 * cct_pkg::CFG_REG_TPS);
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    oven_tps = value;
    @(negedge clk);
  endtask

  task automatic queue_digits(logic [3:0] d0, logic [3:0] d1, logic [3:0] d2, logic [3:0] d3);
    queue_event(cct_pkg::CMD_DIGIT, d0, 3'b000);
    queue_event(cct_pkg::CMD_DIGIT, d1, 3'b111);
    queue_event(cct_pkg::CMD_DIGIT, d2, 3'b010);
    queue_event(cct_pkg::CMD_DIGIT, d3, 3'b101);
  endtask

  task automatic queue_cook_session();
    int         n_digits;
    int         n_steps;
    int         pick;
    logic [3:0] key;
    if ($urandom_range(9) != 0) begin
      queue_event(cct_pkg::CMD_CANCEL, 4'($urandom), 3'($urandom));
      queue_event(cct_pkg::CMD_POLL, 4'($urandom), 3'($urandom));
    end
    n_digits = $urandom_range(9) < 7 ? 4 : $urandom_range(0, 5);
    for (int i = 0; i < n_digits; i++) begin
      if ($urandom_range(11) == 0) key = 4'($urandom);
      else if (i < 2 && $urandom_range(3) != 0) key = 4'd0;
      else key = 4'($urandom_range(9));
      queue_event(cct_pkg::CMD_DIGIT, key, 3'($urandom));
    end
    queue_event(cct_pkg::CMD_POLL, 4'($urandom),
                $urandom_range(9) != 0 ? 3'b111 : 3'($urandom));
    n_steps = $urandom_range(10, 80);
    for (int i = 0; i < n_steps; i++) begin
      pick = $urandom_range(99);
      if (pick < 78) queue_event(cct_pkg::CMD_TICK, 4'($urandom), 3'($urandom));
      else if (pick < 84) queue_event(cct_pkg::CMD_POLL, 4'($urandom), 3'($urandom));
      else if (pick < 90) queue_event(cct_pkg::CMD_POLL, 4'($urandom), 3'b111);
      else if (pick < 93)
        queue_event(cct_pkg::CMD_DIGIT, 4'($urandom_range(9)), 3'($urandom));
      else if (pick < 95) queue_event(cct_pkg::CMD_CANCEL, 4'($urandom), 3'($urandom));
      else queue_event(cct_pkg::cmd_t'($urandom_range(3)), 4'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // one second per tick
    write_tps(8'd1);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_DIGIT, 4'd15, 3'b000);
    queue_digits(4'd9, 4'd9, 4'd9, 4'd9);
    queue_event(cct_pkg::CMD_DIGIT, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b011);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    queue_event(cct_pkg::CMD_DIGIT, 4'd3, 3'b111);
    queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b110);
    queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    queue_event(cct_pkg::CMD_CANCEL, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    queue_digits(4'd0, 4'd1, 4'd0, 4'd0);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_CANCEL, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    queue_digits(4'd0, 4'd0, 4'd0, 4'd1);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b101);

    // zero setting: every tick takes a second
    write_tps(8'd0);
    queue_digits(4'd0, 4'd0, 4'd0, 4'd5);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    repeat (4) queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_CANCEL, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b000);

    // slowest setting, then lowered while the count is high
    write_tps(8'd255);
    queue_digits(4'd9, 4'd9, 4'd5, 4'd9);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    repeat (300) queue_event(cct_pkg::CMD_TICK, 4'($urandom), 3'($urandom));
    write_tps(8'd3);
    repeat (3) queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b011);
    queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);
    queue_event(cct_pkg::CMD_POLL, 4'd0, 3'b111);
    queue_event(cct_pkg::CMD_TICK, 4'd0, 3'b000);

    write_tps(cct_pkg::TPS_RESET);
    while (events_queued < 2000) begin
      repeat (3) queue_cook_session();
      repeat ($urandom_range(0, 10))
        queue_event(cct_pkg::cmd_t'($urandom_range(3)), 4'($urandom), 3'($urandom));
      if ($urandom_range(2) == 0)
        write_tps($urandom_range(3) == 0 ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(1, 6)));
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_display.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/cct_pkg.sv
design/cook_timer_controller.sv
bench/tb_top.sv
